// File: sv/dita_pkg.sv
// Package for the debounced interval timer: beat types, register indexes,
// segment and keypad tables, and the helpers that decode them.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package dita_pkg;

  // Item command codes
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_KEY  = 1'b1
  } dita_cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_BLINK    = 2'd1,
    REG_TPS      = 2'd2
  } dita_reg_e;

  // Keypad entry progress
  typedef enum logic [1:0] {
    ENTRY_NONE  = 2'd0,
    ENTRY_FIRST = 2'd1,
    ENTRY_DONE  = 2'd2
  } dita_entry_e;

  localparam logic [7:0]  SWITCH_MASK    = 8'h80;
  localparam logic [7:0]  ALARM_MASK     = 8'h01;
  localparam logic [7:0]  LED_ALL_OFF    = 8'hFF;
  localparam logic [6:0]  SECONDS_MAX    = 7'd99;
  localparam logic [6:0]  LIMIT_RESET    = 7'd10;
  localparam logic [9:0]  DEBOUNCE_RESET = 10'd20;
  localparam logic [9:0]  BLINK_RESET    = 10'd250;
  localparam logic [15:0] TPS_RESET      = 16'd1000;
  localparam int          NUM_DIGITS     = 10;

  localparam logic [7:0] KEY_CODE [NUM_DIGITS] = '{
    8'h82, 8'h11, 8'h12, 8'h14, 8'h21, 8'h22, 8'h24, 8'h41, 8'h42, 8'h44
  };

  // Input beat
  typedef struct packed {
    dita_cmd_e  cmd;
    logic [7:0] bus_value;
  } dita_item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] led_byte;
    logic [6:0] seg_ones;
    logic [6:0] seg_tens;
    logic [6:0] elapsed_seconds;
    logic [6:0] limit_seconds;
    logic [1:0] entry_stage;
    logic       running;
    logic       alarm;
  } dita_result_t;

  // Configuration write beat
  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } dita_cfg_t;

  // Live configuration registers
  typedef struct packed {
    logic [9:0]  debounce_ticks;
    logic [9:0]  blink_half_period;
    logic [15:0] ticks_per_second;
  } dita_regs_t;

  // One processed item, as seen by the update units
  typedef struct packed {
    logic       tick_go;
    logic       key_go;
    logic [7:0] bus_value;
  } dita_step_t;

  // Timer unit view after the step
  typedef struct packed {
    logic [7:0] led_byte;
    logic [6:0] seg_ones;
    logic [6:0] seg_tens;
    logic [6:0] seconds;
    logic       running;
    logic       alarm;
  } dita_tmr_t;

  // Keypad unit view
  typedef struct packed {
    logic [6:0] limit_cur;
    logic [6:0] limit_nxt;
    logic [1:0] stage_nxt;
  } dita_kp_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } dita_key_t;

  // Match a scan code against the keypad table; zero never matches
  function automatic dita_key_t key_decode(input logic [7:0] scan);
    dita_key_t res;
    res = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (scan == KEY_CODE[d]) begin
        res.hit   = 1'b1;
        res.digit = 4'(d);
      end
    end
    return res;
  endfunction

  // Seven-segment code of one decimal digit (active-low segments)
  function automatic logic [6:0] seg_encode(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0:    code = 7'h40;
      4'd1:    code = 7'h79;
      4'd2:    code = 7'h24;
      4'd3:    code = 7'h30;
      4'd4:    code = 7'h19;
      4'd5:    code = 7'h12;
      4'd6:    code = 7'h02;
      4'd7:    code = 7'h78;
      4'd8:    code = 7'h00;
      4'd9:    code = 7'h18;
      default: code = 7'h40;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: sv/dita_intf.sv
// Valid/ready channel interfaces of the interval timer: item, result, config.
// Depends on dita_pkg for the beat types.
`timescale 1ns / 1ps
`default_nettype none

interface dita_item_if;
  logic                   valid;
  logic                   ready;
  dita_pkg::dita_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dita_result_if;
  logic                   valid;
  logic                   ready;
  dita_pkg::dita_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dita_cfg_if;
  logic                   valid;
  logic                   ready;
  dita_pkg::dita_cfg_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/dita_keypad.sv
// Keypad threshold entry: two decimal digits form the alarm limit.
// Depends on dita_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dita_keypad (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dita_pkg::dita_step_t step_i,
  input  logic                 restart_i,
  output dita_pkg::dita_kp_t   kp_o
);

  logic [1:0]          stage_q, stage_d;
  logic [3:0]          first_q, first_d;
  logic [6:0]          limit_q, limit_d;
  dita_pkg::dita_key_t key;
  logic [6:0]          sum;

  assign key = dita_pkg::key_decode(step_i.bus_value);
  // first * 10 + digit, at most 99
  assign sum = {first_q, 3'b000} + {2'b00, first_q, 1'b0} + {3'b000, key.digit};

  always_comb begin
    stage_d = stage_q;
    first_d = first_q;
    limit_d = limit_q;
    if (step_i.key_go && key.hit) begin
      case (stage_q)
        dita_pkg::ENTRY_NONE: begin
          first_d = key.digit;
          stage_d = dita_pkg::ENTRY_FIRST;
        end
        dita_pkg::ENTRY_FIRST: begin
          limit_d = (sum == 7'd0) ? 7'd1 : sum;
          stage_d = dita_pkg::ENTRY_DONE;
        end
        default: ;
      endcase
    end
    // Falling switch edge reopens entry
    if (restart_i) begin
      stage_d = dita_pkg::ENTRY_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= dita_pkg::ENTRY_NONE;
      first_q <= '0;
      limit_q <= dita_pkg::LIMIT_RESET;
    end else begin
      stage_q <= stage_d;
      first_q <= first_d;
      limit_q <= limit_d;
    end
  end

  assign kp_o.limit_cur = limit_q;
  assign kp_o.limit_nxt = limit_d;
  assign kp_o.stage_nxt = stage_d;

endmodule

`default_nettype wire

// File: sv/dita_timer.sv
// Tick path: switch debounce, edge handling, seconds count, blink, alarm.
// Depends on dita_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dita_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dita_pkg::dita_regs_t regs_i,
  input  dita_pkg::dita_step_t step_i,
  input  logic [6:0]           limit_i,
  output logic                 restart_o,
  output dita_pkg::dita_tmr_t  tmr_o
);

  logic        raw_q, raw_d;
  logic        stable_q, stable_d;
  logic [9:0]  scnt_q, scnt_d;
  logic [15:0] tick_q, tick_d;
  logic [6:0]  sec_q, sec_d;
  logic [7:0]  bcd_q, bcd_d;     // seconds as two BCD digits
  logic [7:0]  shown_q, shown_d; // displayed value, BCD
  logic        run_q, run_d;
  logic        alarm_q, alarm_d;
  logic [9:0]  blink_q, blink_d;
  logic        led0_q, led0_d;
  logic        now;
  logic        new_sec;

  assign now = |(step_i.bus_value & dita_pkg::SWITCH_MASK);

  always_comb begin
    raw_d     = raw_q;
    stable_d  = stable_q;
    scnt_d    = scnt_q;
    tick_d    = tick_q;
    sec_d     = sec_q;
    bcd_d     = bcd_q;
    shown_d   = shown_q;
    run_d     = run_q;
    alarm_d   = alarm_q;
    blink_d   = blink_q;
    led0_d    = led0_q;
    new_sec   = 1'b0;
    restart_o = 1'b0;
    if (step_i.tick_go) begin
      // Debounce and edge handling
      if (now != raw_q) begin
        raw_d  = now;
        scnt_d = '0;
      end else if (scnt_q < regs_i.debounce_ticks) begin
        scnt_d = scnt_q + 10'd1;
      end else if (stable_q != raw_q) begin
        stable_d = raw_q;
        if (raw_q) begin
          tick_d  = '0;
          sec_d   = '0;
          bcd_d   = '0;
          shown_d = '0;
          run_d   = 1'b1;
        end else begin
          run_d     = 1'b0;
          restart_o = 1'b1;
        end
        alarm_d = 1'b0;
        led0_d  = 1'b1;
      end
      // Tick count into seconds
      if (run_d) begin
        tick_d = tick_d + 16'd1;
        if (tick_d >= regs_i.ticks_per_second) begin
          tick_d  = '0;
          new_sec = 1'b1;
          if (sec_d < dita_pkg::SECONDS_MAX) begin
            sec_d = sec_d + 7'd1;
            if (bcd_d[3:0] == 4'd9) begin
              bcd_d = {bcd_d[7:4] + 4'd1, 4'd0};
            end else begin
              bcd_d = {bcd_d[7:4], bcd_d[3:0] + 4'd1};
            end
          end
        end
      end
      // Blink while alarmed
      if (alarm_d) begin
        blink_d = blink_d + 10'd1;
        if (blink_d >= regs_i.blink_half_period) begin
          blink_d = '0;
          led0_d  = ~led0_d;
        end
      end else begin
        led0_d = 1'b1;
      end
      // Alarm check once per second
      if (new_sec) begin
        shown_d = bcd_d;
        if (run_d && (sec_d >= limit_i) && !alarm_d) begin
          alarm_d = 1'b1;
          blink_d = '0;
          led0_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      scnt_q   <= '0;
      tick_q   <= '0;
      sec_q    <= '0;
      bcd_q    <= '0;
      shown_q  <= '0;
      run_q    <= 1'b0;
      alarm_q  <= 1'b0;
      blink_q  <= '0;
      led0_q   <= 1'b1;
    end else begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      scnt_q   <= scnt_d;
      tick_q   <= tick_d;
      sec_q    <= sec_d;
      bcd_q    <= bcd_d;
      shown_q  <= shown_d;
      run_q    <= run_d;
      alarm_q  <= alarm_d;
      blink_q  <= blink_d;
      led0_q   <= led0_d;
    end
  end

  // D7 follows the accepted level, other unused LEDs stay dark
  assign tmr_o.led_byte = (dita_pkg::LED_ALL_OFF
                           & ~(dita_pkg::SWITCH_MASK | dita_pkg::ALARM_MASK))
                          | (stable_d ? 8'h00 : dita_pkg::SWITCH_MASK)
                          | (led0_d ? dita_pkg::ALARM_MASK : 8'h00);
  assign tmr_o.seg_ones = dita_pkg::seg_encode(shown_d[3:0]);
  assign tmr_o.seg_tens = dita_pkg::seg_encode(shown_d[7:4]);
  assign tmr_o.seconds  = sec_d;
  assign tmr_o.running  = run_d;
  assign tmr_o.alarm    = alarm_d;

endmodule

`default_nettype wire

// File: sv/debounced_interval_timer_alarm_core.sv
// Top level of the debounced interval timer with alarm: channel registers,
// config registers, and the timer and keypad update units.
// Depends on dita_pkg, dita_intf, dita_timer, dita_keypad.
//
//   Channel  Dir  Beat          Contents
//   in_ch    in   dita_item_t   cmd (tick or key), bus_value (port byte/scan)
//   out_ch   out  dita_result_t LEDs, segments, seconds, limit, entry, flags
//   cfg_ch   in   dita_cfg_t    register index and write data
//
// One item per cycle while out_ch is ready: an accepted beat lands in the input
// register; once the output register is free or being emptied, the timer and
// keypad logic update on it and the result beat is captured in the output
// register. The input register keeps taking beats while a result waits;
// only a stalled output with a full input register holds in_ch.ready low.
// Reset is asynchronous and clears all state but the payload registers; cfg_ch is always ready.
`timescale 1ns / 1ps
`default_nettype none

module debounced_interval_timer_alarm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  dita_item_if.sink           in_ch,
  dita_result_if.source       out_ch,
  dita_cfg_if.sink            cfg_ch
);

  // Input register
  logic                   in_vld_q;
  dita_pkg::dita_item_t   in_q;
  // Output register
  logic                   out_vld_q;
  dita_pkg::dita_result_t out_q, out_d;
  // Config registers
  dita_pkg::dita_regs_t   regs_q;

  logic                   advance;
  dita_pkg::dita_step_t   step;
  dita_pkg::dita_tmr_t    tmr;
  dita_pkg::dita_kp_t     kp;
  logic                   restart;

  // Move the held beat into the output register when that slot frees up
  assign advance      = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || advance;
  assign cfg_ch.ready = 1'b1;

  assign step.tick_go   = advance && (in_q.cmd == dita_pkg::CMD_TICK);
  assign step.key_go    = advance && (in_q.cmd == dita_pkg::CMD_KEY);
  assign step.bus_value = in_q.bus_value;

  dita_timer u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .regs_i    (regs_q),
    .step_i    (step),
    .limit_i   (kp.limit_cur),
    .restart_o (restart),
    .tmr_o     (tmr)
  );

  dita_keypad u_keypad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (restart),
    .kp_o      (kp)
  );

  always_comb begin
    out_d.led_byte        = tmr.led_byte;
    out_d.seg_ones        = tmr.seg_ones;
    out_d.seg_tens        = tmr.seg_tens;
    out_d.elapsed_seconds = tmr.seconds;
    out_d.limit_seconds   = kp.limit_nxt;
    out_d.entry_stage     = kp.stage_nxt;
    out_d.running         = tmr.running;
    out_d.alarm           = tmr.alarm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold until the next beat
  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q <= in_ch.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Config writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.debounce_ticks    <= dita_pkg::DEBOUNCE_RESET;
      regs_q.blink_half_period <= dita_pkg::BLINK_RESET;
      regs_q.ticks_per_second  <= dita_pkg::TPS_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.data.index)
        dita_pkg::REG_DEBOUNCE: regs_q.debounce_ticks    <= cfg_ch.data.data[9:0];
        dita_pkg::REG_BLINK:    regs_q.blink_half_period <= cfg_ch.data.data[9:0];
        dita_pkg::REG_TPS:      regs_q.ticks_per_second  <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_q;

  // The alarm can only be up while timing runs
  a_alarm_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.alarm || out_q.running))
    else $error("alarm reported while not running");

  // Seconds saturate, limit stays in 1..99, entry stage never past done
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.elapsed_seconds <= dita_pkg::SECONDS_MAX
                   && out_q.limit_seconds >= 7'd1
                   && out_q.limit_seconds <= dita_pkg::SECONDS_MAX
                   && out_q.entry_stage != 2'd3))
    else $error("result field out of range");

  // D0 is dark whenever no alarm is set; D1..D6 always dark
  a_led_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.alarm || out_q.led_byte[0])
                   && out_q.led_byte[6:1] == 6'h3F))
    else $error("LED pattern inconsistent with alarm state");

  // A processed beat always shows up in the output register next cycle
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed beat lost before output register");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for debounced_interval_timer_alarm_core: directed table, then
// episodes of switch presses, releases, bounces and keypad entry under several timings.
// Depends on dita_pkg, dita_intf and the RTL of the core.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF_NS     = 10;
  localparam int RESET_CYCLES    = 10;
  // Longest stretch with no beat on any channel, longer than the hold-off below.
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASE_ITEMS     = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  // Settling time after the queues drain.
  localparam int TAIL_CYCLES     = 8;
  localparam int RANDOM_PHASES   = 8;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Seven-segment codes, active-low, digits 0..9
  localparam logic [6:0] SEG_OF_DIGIT [dita_pkg::NUM_DIGITS] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
  };

  typedef enum logic [1:0] {
    GAP_NONE = 2'd0,
    GAP_SEND = 2'd1,
    GAP_RECV = 2'd2,
    GAP_BOTH = 2'd3
  } gap_mode_e;

  // One input beat, with a hand-written readout where typed is set
  typedef struct packed {
    dita_pkg::dita_item_t   item;
    logic                   typed;
    dita_pkg::dita_result_t want;
  } stim_beat_t;

  localparam dita_pkg::dita_result_t READOUT_RESET = '{
    led_byte: dita_pkg::LED_ALL_OFF, seg_ones: 7'h40, seg_tens: 7'h40,
    elapsed_seconds: 7'd0, limit_seconds: dita_pkg::LIMIT_RESET,
    entry_stage: dita_pkg::ENTRY_NONE, running: 1'b0, alarm: 1'b0
  };
  localparam dita_pkg::dita_result_t READOUT_FIRST = '{
    led_byte: dita_pkg::LED_ALL_OFF, seg_ones: 7'h40, seg_tens: 7'h40,
    elapsed_seconds: 7'd0, limit_seconds: dita_pkg::LIMIT_RESET,
    entry_stage: dita_pkg::ENTRY_FIRST, running: 1'b0, alarm: 1'b0
  };
  localparam dita_pkg::dita_result_t READOUT_LIMIT1 = '{
    led_byte: dita_pkg::LED_ALL_OFF, seg_ones: 7'h40, seg_tens: 7'h40,
    elapsed_seconds: 7'd0, limit_seconds: 7'd1,
    entry_stage: dita_pkg::ENTRY_DONE, running: 1'b0, alarm: 1'b0
  };

  // Directed table, run with debounce 0, blink 0 and ticks per second 0
  localparam int DIR_ROWS = 24;
  localparam stim_beat_t DIRECTED [DIR_ROWS] = '{
    '{'{dita_pkg::CMD_TICK, 8'h00}, 1'b1, READOUT_RESET},   // idle tick, nothing moves
    '{'{dita_pkg::CMD_KEY,  8'h00}, 1'b1, READOUT_RESET},   // scan code zero is ignored
    '{'{dita_pkg::CMD_KEY,  8'h13}, 1'b1, READOUT_RESET},   // not a digit
    '{'{dita_pkg::CMD_KEY,  8'hFF}, 1'b1, READOUT_RESET},   // not a digit, all bits set
    '{'{dita_pkg::CMD_KEY,  8'h82}, 1'b1, READOUT_FIRST},   // first digit 0
    '{'{dita_pkg::CMD_KEY,  8'h82}, 1'b1, READOUT_LIMIT1},  // 00 becomes 1
    '{'{dita_pkg::CMD_KEY,  8'h44}, 1'b1, READOUT_LIMIT1},  // third key ignored
    '{'{dita_pkg::CMD_TICK, 8'h80}, 1'b1, READOUT_LIMIT1},  // raw level flips, not accepted
    '{'{dita_pkg::CMD_TICK, 8'h80}, 1'b0, '0},    // accept on second sight, alarm at 1 s
    '{'{dita_pkg::CMD_TICK, 8'hFF}, 1'b0, '0},    // blink toggles every tick
    '{'{dita_pkg::CMD_TICK, 8'h80}, 1'b0, '0},
    '{'{dita_pkg::CMD_KEY,  8'h11}, 1'b0, '0},    // key while timing, entry already done
    '{'{dita_pkg::CMD_TICK, 8'h7F}, 1'b0, '0},
    '{'{dita_pkg::CMD_TICK, 8'h00}, 1'b0, '0},    // falling edge: stop, clear alarm
    '{'{dita_pkg::CMD_KEY,  8'h44}, 1'b0, '0},
    '{'{dita_pkg::CMD_KEY,  8'h44}, 1'b0, '0},    // limit 99
    '{'{dita_pkg::CMD_TICK, 8'h80}, 1'b0, '0},
    '{'{dita_pkg::CMD_TICK, 8'h80}, 1'b0, '0},    // restart timing from zero
    '{'{dita_pkg::CMD_TICK, 8'h80}, 1'b0, '0},
    '{'{dita_pkg::CMD_KEY,  8'h41}, 1'b0, '0},
    '{'{dita_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
    '{'{dita_pkg::CMD_TICK, 8'h00}, 1'b0, '0},
    '{'{dita_pkg::CMD_KEY,  8'h41}, 1'b0, '0},
    '{'{dita_pkg::CMD_KEY,  8'h24}, 1'b0, '0}     // limit 76
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dita_item_if   item_ch ();
  dita_result_if result_ch ();
  dita_cfg_if    cfg_ch ();

  debounced_interval_timer_alarm_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (item_ch),
    .out_ch (result_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // Timer model: live registers and state
  logic [9:0]            cfg_debounce;
  logic [9:0]            cfg_blink;
  logic [15:0]           cfg_tps;
  logic                  sw_raw;
  logic                  sw_stable;
  logic [9:0]            settle_cnt;
  logic [15:0]           ms_cnt;
  logic [6:0]            sec_cnt;
  logic                  timing_on;
  logic                  alarm_up;
  logic [9:0]            blink_cnt;
  logic [6:0]            limit_secs;
  dita_pkg::dita_entry_e entry;
  logic [3:0]            first_digit;
  logic [7:0]            led_state;
  logic [6:0]            shown_secs;

  stim_beat_t             item_backlog [$];
  dita_pkg::dita_result_t pending_readouts [$];
  int unsigned            mismatch_count;
  gap_mode_e              gap_mode;
  int                     hold_off_left;
  logic                   item_beat_done;

  // Apply one beat to the timer model and return the readout it yields.
  // Tick order: debounce and edge, D7, ms count, blink, alarm check.
  function automatic dita_pkg::dita_result_t advance_timer(dita_pkg::dita_item_t it);
    dita_pkg::dita_result_t r;
    logic         level;
    logic         new_sec;
    logic         hit;
    logic [3:0]   digit;
    logic [6:0]   t;
    new_sec = 1'b0;
    hit     = 1'b0;
    digit   = '0;
    if (it.cmd == dita_pkg::CMD_TICK) begin
      level = |(it.bus_value & dita_pkg::SWITCH_MASK);
      if (level != sw_raw) begin
        sw_raw     = level;
        settle_cnt = '0;
      end else if (settle_cnt < cfg_debounce) begin
        settle_cnt = settle_cnt + 10'd1;
      end else if (sw_stable != sw_raw) begin
        sw_stable = sw_raw;
        if (sw_stable) begin
          ms_cnt     = '0;
          sec_cnt    = '0;
          timing_on  = 1'b1;
          shown_secs = '0;
        end else begin
          timing_on = 1'b0;
          entry     = dita_pkg::ENTRY_NONE;
        end
        alarm_up  = 1'b0;
        led_state = led_state | dita_pkg::ALARM_MASK;
      end
      led_state = sw_stable ? (led_state & ~dita_pkg::SWITCH_MASK)
                            : (led_state | dita_pkg::SWITCH_MASK);
      if (timing_on) begin
        ms_cnt = ms_cnt + 16'd1;
        if (ms_cnt >= cfg_tps) begin
          ms_cnt = '0;
          if (sec_cnt < dita_pkg::SECONDS_MAX) sec_cnt = sec_cnt + 7'd1;
          new_sec = 1'b1;
        end
      end
      if (alarm_up) begin
        blink_cnt = blink_cnt + 10'd1;
        if (blink_cnt >= cfg_blink) begin
          blink_cnt = '0;
          led_state = led_state ^ dita_pkg::ALARM_MASK;
        end
      end else begin
        led_state = led_state | dita_pkg::ALARM_MASK;
      end
      if (new_sec) begin
        shown_secs = sec_cnt;
        if (timing_on && sec_cnt >= limit_secs && !alarm_up) begin
          alarm_up  = 1'b1;
          blink_cnt = '0;
          led_state = led_state & ~dita_pkg::ALARM_MASK;
        end
      end
    end else begin
      for (int d = 0; d < dita_pkg::NUM_DIGITS; d++) begin
        if (it.bus_value == dita_pkg::KEY_CODE[d]) begin
          hit   = 1'b1;
          digit = 4'(d);
        end
      end
      if (hit) begin
        if (entry == dita_pkg::ENTRY_NONE) begin
          first_digit = digit;
          entry       = dita_pkg::ENTRY_FIRST;
        end else if (entry == dita_pkg::ENTRY_FIRST) begin
          t = 7'(first_digit) * 7'd10 + 7'(digit);
          if (t == 7'd0) t = 7'd1;
          limit_secs = t;
          entry      = dita_pkg::ENTRY_DONE;
        end
      end
    end
    r.led_byte        = led_state;
    r.seg_ones        = SEG_OF_DIGIT[shown_secs % 10];
    r.seg_tens        = SEG_OF_DIGIT[shown_secs / 10];
    r.elapsed_seconds = sec_cnt;
    r.limit_seconds   = limit_secs;
    r.entry_stage     = entry;
    r.running         = timing_on;
    r.alarm           = alarm_up;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Roll for an idle cycle on one side of the core
  function automatic bit gap_roll(gap_mode_e side);
    int unsigned roll;
    roll = $urandom_range(99);
    if (gap_mode == GAP_BOTH) return roll < 35;
    return (gap_mode == side) && (roll < 69);
  endfunction

  // Sample every handshake at the rising edge: predict accepted items, check
  // result beats against the oldest readout, and track register writes.
  always @(posedge clk_i) begin
    dita_pkg::dita_result_t want;
    dita_pkg::dita_result_t got;
    if (!rst_ni) begin
      item_beat_done = 1'b0;
    end else begin
      item_beat_done = item_ch.valid && item_ch.ready;
      if (item_beat_done) begin
        want = advance_timer(item_ch.data);
        if (item_backlog[0].typed) want = item_backlog[0].want;
        pending_readouts.push_back(want);
        void'(item_backlog.pop_front());
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_readouts.size() == 0) begin
          $error("result beat with no readout waiting");
          mismatch_count++;
        end else begin
          want = pending_readouts.pop_front();
          got  = result_ch.data;
          check_field("led_byte", want.led_byte, got.led_byte);
          check_field("seg_ones", want.seg_ones, got.seg_ones);
          check_field("seg_tens", want.seg_tens, got.seg_tens);
          check_field("elapsed_seconds", want.elapsed_seconds, got.elapsed_seconds);
          check_field("limit_seconds", want.limit_seconds, got.limit_seconds);
          check_field("entry_stage", want.entry_stage, got.entry_stage);
          check_field("running", want.running, got.running);
          check_field("alarm", want.alarm, got.alarm);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          dita_pkg::REG_DEBOUNCE: cfg_debounce = cfg_ch.data.data[9:0];
          dita_pkg::REG_BLINK:    cfg_blink    = cfg_ch.data.data[9:0];
          dita_pkg::REG_TPS:      cfg_tps      = cfg_ch.data.data;
          default: ;  // drop writes to unused indexes
        endcase
      end
    end
  end

  // Sender: hold the beat until taken, then offer the next or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!item_ch.valid || item_beat_done)) begin
      if (item_backlog.size() != 0 && !gap_roll(GAP_SEND)) begin
        item_ch.valid <= 1'b1;
        item_ch.data  <= item_backlog[0].item;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while a hold-off is counting.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_left > 0) begin
        hold_off_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !gap_roll(GAP_RECV);
      end
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** debounced_interval_timer_alarm_core: FAILED **");
    $finish;
  end

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: index, data: value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Write all three timing registers; junk in the upper bits of the 10-bit ones
  task automatic set_timing(input logic [9:0] debounce, input logic [9:0] blink,
                            input logic [15:0] tps);
    write_reg(dita_pkg::REG_DEBOUNCE, {6'($urandom), debounce});
    write_reg(dita_pkg::REG_BLINK, {6'($urandom), blink});
    write_reg(dita_pkg::REG_TPS, tps);
  endtask

  task automatic wait_drained();
    while (item_backlog.size() != 0 || pending_readouts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_beat(input dita_pkg::dita_cmd_e op, input logic [7:0] bus);
    item_backlog.push_back('{item: '{cmd: op, bus_value: bus}, typed: 1'b0, want: '0});
  endtask

  // Hold the switch at one level for len ticks, with the odd key press mixed in
  task automatic push_hold(input logic level, input int unsigned len);
    repeat (len) begin
      if ($urandom_range(99) < 8) begin
        push_beat(dita_pkg::CMD_KEY,
                  dita_pkg::KEY_CODE[$urandom_range(dita_pkg::NUM_DIGITS - 1)]);
      end
      push_beat(dita_pkg::CMD_TICK, {level, 7'($urandom)});
    end
  endtask

  // Mostly well-formed presses, releases and digit entry; some bounce and noise
  task automatic queue_episodes(input int unsigned count);
    int unsigned kind;
    while (item_backlog.size() < count) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        push_hold(1'b1, cfg_debounce + 1 +
                  (($urandom_range(4) == 0) ? $urandom_range(130, 60) : $urandom_range(40)));
      end else if (kind < 65) begin
        push_hold(1'b0, cfg_debounce + 1 + $urandom_range(30));
      end else if (kind < 80) begin
        repeat ($urandom_range(3, 1)) begin
          push_beat(dita_pkg::CMD_KEY, ($urandom_range(99) < 85) ?
                    dita_pkg::KEY_CODE[$urandom_range(dita_pkg::NUM_DIGITS - 1)] :
                    8'($urandom));
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(3, 1)) push_beat(dita_pkg::CMD_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(5, 1)) begin
          push_beat(dita_pkg::dita_cmd_e'($urandom_range(1)), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    gap_mode        = GAP_NONE;
    hold_off_left   = 0;
    mismatch_count  = 0;
    item_beat_done  = 1'b0;
    // Power-on state of the model
    cfg_debounce = dita_pkg::DEBOUNCE_RESET;
    cfg_blink    = dita_pkg::BLINK_RESET;
    cfg_tps      = dita_pkg::TPS_RESET;
    sw_raw       = 1'b0;
    sw_stable    = 1'b0;
    settle_cnt   = '0;
    ms_cnt       = '0;
    sec_cnt      = '0;
    timing_on    = 1'b0;
    alarm_up     = 1'b0;
    blink_cnt    = '0;
    limit_secs   = dita_pkg::LIMIT_RESET;
    entry        = dita_pkg::ENTRY_NONE;
    first_digit  = '0;
    led_state    = dita_pkg::LED_ALL_OFF;
    shown_secs   = '0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unused index must leave the timing alone
    write_reg(REG_UNUSED, 16'($urandom));
    set_timing(10'd0, 10'd0, 16'd0);
    @(posedge clk_i);
    foreach (DIRECTED[i]) item_backlog.push_back(DIRECTED[i]);
    wait_drained();

    // Random phases: cycle through the idling patterns, timings mostly small so that
    // seconds, saturation and blinking all show up within a phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_timing(10'd0, 10'd1, 16'd1);
        1: set_timing(10'd1, 10'd0, 16'd0);
        2: set_timing(10'd3, 10'd2, 16'd2);
        default: begin
          set_timing(10'($urandom_range(4)), 10'($urandom_range(8)),
                     ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(4)));
        end
      endcase
      gap_mode = gap_mode_e'(p % 4);
      @(posedge clk_i);
      // Stall the result side while items keep coming, so the core backs up
      if (p == 4) hold_off_left = HOLD_OFF_CYCLES;
      queue_episodes(PHASE_ITEMS);
      wait_drained();
    end

    // Long debounce and blink: release first, then hold long enough to accept,
    // saturate the seconds, set the alarm and see D0 toggle, then release again.
    set_timing(10'd60, 10'd80, 16'd0);
    gap_mode = GAP_BOTH;
    @(posedge clk_i);
    push_hold(1'b0, 70);
    push_hold(1'b1, 260);
    push_hold(1'b0, 70);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("** debounced_interval_timer_alarm_core: PASSED **");
    end else begin
      $display("** debounced_interval_timer_alarm_core: FAILED **");
    end
    $finish;
  end

endmodule
